### hdl/fbpa_pkg.sv
// shared types and constants of the fixed block pool allocator
package fbpa_pkg;

  localparam int OP_W   = 2;
  localparam int SIZE_W = 16;
  localparam int IDX_W  = 5;
  localparam int CNT_W  = 6;

  localparam int BLOCK_COUNT_DEF = 32;
  localparam logic [SIZE_W-1:0] BLOCK_BYTES = 16'd64;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_STATS   = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LINK,
    ST_POP
  } state_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

### hdl/fbpa_ifs.sv
// request and result channel interfaces of the block pool allocator
interface fbpa_in_if;
  import fbpa_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [SIZE_W-1:0] request_size;
  logic [IDX_W-1:0]  release_index;
  logic              release_is_null;

  modport source (output valid, output opcode, output request_size,
                  output release_index, output release_is_null, input ready);
  modport sink   (input valid, input opcode, input request_size,
                  input release_index, input release_is_null, output ready);
endinterface

interface fbpa_out_if;
  import fbpa_pkg::*;

  logic             valid;
  logic             ready;
  logic             status;
  logic [IDX_W-1:0] granted_index;
  logic [CNT_W-1:0] total_blocks;
  logic [CNT_W-1:0] used_blocks;
  logic [CNT_W-1:0] free_blocks;

  modport source (output valid, output status, output granted_index,
                  output total_blocks, output used_blocks, output free_blocks,
                  input ready);
  modport sink   (input valid, input status, input granted_index,
                  input total_blocks, input used_blocks, input free_blocks,
                  output ready);
endinterface

### hdl/fbpa_ram.sv
// generic single write port ram with registered read
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/fbpa_ctrl.sv
// free list controller: head, count, pool linking sweep and result register
module fbpa_ctrl #(
  parameter int BLOCK_COUNT = fbpa_pkg::BLOCK_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  fbpa_in_if.sink                    in_ch,
  fbpa_out_if.source                 out_ch,
  output fbpa_pkg::mem_req_t         mem_req,
  input  logic [fbpa_pkg::IDX_W-1:0] mem_rdata
);
  import fbpa_pkg::*;

  localparam int AW = $clog2(BLOCK_COUNT);
  localparam logic [CNT_W-1:0] TOTAL = CNT_W'(BLOCK_COUNT);
  localparam logic [AW-1:0] LAST = AW'(BLOCK_COUNT - 1);

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] free_r, free_nxt;
  logic             init_r, init_nxt;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic             size_ok_r, size_ok_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             status_r, status_nxt;
  logic [IDX_W-1:0] granted_r, granted_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] freeo_r, freeo_nxt;

  logic in_ready;
  logic accept;
  logic size_ok;
  logic rel_ok;
  op_t  op;

  assign op       = op_t'(in_ch.opcode);
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept   = in_ch.valid && in_ready;
  assign size_ok  = in_ch.request_size <= BLOCK_BYTES;
  assign rel_ok   = init_r && !in_ch.release_is_null &&
                    ({1'b0, in_ch.release_index} < TOTAL) && (free_r < TOTAL);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    free_nxt      = free_r;
    init_nxt      = init_r;
    cnt_nxt       = cnt_r;
    size_ok_nxt   = size_ok_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    granted_nxt   = granted_r;
    total_nxt     = total_r;
    used_nxt      = used_r;
    freeo_nxt     = freeo_r;
    mem_req       = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_ALLOC: begin
              if (!init_r) begin
                cnt_nxt     = '0;
                size_ok_nxt = size_ok;
                state_nxt   = ST_LINK;
              end else if (!size_ok || free_r == '0) begin
                out_valid_nxt = 1'b1;
                status_nxt    = 1'b1;
                granted_nxt   = '0;
                total_nxt     = '0;
                used_nxt      = '0;
                freeo_nxt     = '0;
              end else begin
                mem_req.raddr = head_r;
                state_nxt     = ST_POP;
              end
            end
            OP_RELEASE: begin
              if (rel_ok) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = in_ch.release_index;
                mem_req.wdata = head_r;
                head_nxt      = in_ch.release_index;
                free_nxt      = free_r + 1'b1;
              end
              out_valid_nxt = 1'b1;
              status_nxt    = 1'b0;
              granted_nxt   = '0;
              total_nxt     = '0;
              used_nxt      = '0;
              freeo_nxt     = '0;
            end
            OP_STATS: begin
              out_valid_nxt = 1'b1;
              status_nxt    = 1'b0;
              granted_nxt   = '0;
              total_nxt     = init_r ? TOTAL : '0;
              used_nxt      = init_r ? (TOTAL - free_r) : '0;
              freeo_nxt     = init_r ? free_r : '0;
            end
            default: begin
              out_valid_nxt = 1'b1;
              status_nxt    = 1'b0;
              granted_nxt   = '0;
              total_nxt     = '0;
              used_nxt      = '0;
              freeo_nxt     = '0;
            end
          endcase
        end
      end
      ST_LINK: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = IDX_W'(cnt_r);
        mem_req.wdata = (cnt_r == LAST) ? '0 : (IDX_W'(cnt_r) + 1'b1);
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          init_nxt = 1'b1;
          head_nxt = '0;
          free_nxt = TOTAL;
          if (size_ok_r) begin
            mem_req.raddr = '0;
            state_nxt     = ST_POP;
          end else begin
            out_valid_nxt = 1'b1;
            status_nxt    = 1'b1;
            granted_nxt   = '0;
            total_nxt     = '0;
            used_nxt      = '0;
            freeo_nxt     = '0;
            state_nxt     = ST_IDLE;
          end
        end
      end
      ST_POP: begin
        head_nxt      = mem_rdata;
        free_nxt      = free_r - 1'b1;
        out_valid_nxt = 1'b1;
        status_nxt    = 1'b0;
        granted_nxt   = head_r;
        total_nxt     = '0;
        used_nxt      = '0;
        freeo_nxt     = '0;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      free_r      <= '0;
      init_r      <= 1'b0;
      cnt_r       <= '0;
      size_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      free_r      <= free_nxt;
      init_r      <= init_nxt;
      cnt_r       <= cnt_nxt;
      size_ok_r   <= size_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    granted_r <= granted_nxt;
    total_r   <= total_nxt;
    used_r    <= used_nxt;
    freeo_r   <= freeo_nxt;
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.granted_index = granted_r;
  assign out_ch.total_blocks  = total_r;
  assign out_ch.used_blocks   = used_r;
  assign out_ch.free_blocks   = freeo_r;

  a_free_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= TOTAL)
    else $error("free count above pool size");

  a_uninit_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !init_r |-> free_r == '0)
    else $error("free count nonzero before pool linked");

  a_busy_slot_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LINK || state_r == ST_POP) |-> !out_valid_r)
    else $error("result slot occupied during multi-cycle op");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_POP |=> free_r == $past(free_r) - 1'b1 && out_valid_r)
    else $error("pop did not decrement free count or post result");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_POP |-> free_r != '0)
    else $error("pop issued on empty list");

endmodule

### hdl/fixed_block_pool_allocator_unit.sv
// top level of the fixed block pool allocator
//
// in_ch carries one request word: opcode (allocate, release, statistics,
// no-op), request_size, release_index and release_is_null. out_ch returns
// exactly one result word per request, in request order.
// the free list successor links live in a one-port-write, one-port-read ram
// with registered read; head and free count sit in registers.
// release, statistics and no-op write their result word straight from the
// idle state. allocate first registers the ram read of the head's successor
// and posts its result from the pop state. the first allocate after reset
// also links the whole pool first, one ram entry per cycle.
// reset empties the pool state: statistics read zero and releases are
// ignored until the first allocate links the pool.
// results sit in an output register; in the idle state a new request is taken
// while that register is empty or holds a word that the receiver takes in the
// same cycle. when the receiver stalls, in_ch.ready falls until the word is taken.
module fixed_block_pool_allocator_unit #(
  parameter int BLOCK_COUNT = fbpa_pkg::BLOCK_COUNT_DEF
) (
  input logic        clk,
  input logic        rst_n,
  fbpa_in_if.sink    in_ch,
  fbpa_out_if.source out_ch
);
  import fbpa_pkg::*;

  localparam int AW = $clog2(BLOCK_COUNT);

  mem_req_t         mem_req;
  logic [IDX_W-1:0] mem_rdata;

  fbpa_ctrl #(
    .BLOCK_COUNT(BLOCK_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .mem_req  (mem_req),
    .mem_rdata(mem_rdata)
  );

  fbpa_ram #(
    .WIDTH(IDX_W),
    .DEPTH(BLOCK_COUNT)
  ) u_link_ram (
    .clk  (clk),
    .we   (mem_req.we),
    .waddr(mem_req.waddr[AW-1:0]),
    .wdata(mem_req.wdata),
    .raddr(mem_req.raddr[AW-1:0]),
    .rdata(mem_rdata)
  );

endmodule

### tb/sv/tb.sv
// testbench of the fixed block pool allocator: request words checked against a local pool model
module tb;
  import fbpa_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int IDLE_PCT    = 16;

  typedef struct packed {
    logic             status;
    logic [IDX_W-1:0] granted;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] avail;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n;

  fbpa_in_if  in_ch ();
  fbpa_out_if out_ch ();

  fixed_block_pool_allocator_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  // pool model
  logic [IDX_W-1:0] succ_link [BLOCK_COUNT_DEF];
  logic [IDX_W-1:0] list_head;
  logic [CNT_W-1:0] free_cnt;
  bit               pool_linked;

  reply_t           pool_replies [$];
  logic [IDX_W-1:0] held_blocks [$];
  int               error_count = 0;
  int               cycle_count = 0;
  bit               quiet_run;

  function automatic reply_t pool_step(op_t op, logic [SIZE_W-1:0] size,
                                       logic [IDX_W-1:0] idx, logic is_null);
    reply_t r;
    int     i;
    r = '0;
    case (op)
      OP_ALLOC: begin
        if (!pool_linked) begin
          for (i = 0; i < BLOCK_COUNT_DEF; i++) begin
            succ_link[i] = IDX_W'((i + 1) % BLOCK_COUNT_DEF);
          end
          list_head   = '0;
          free_cnt    = CNT_W'(BLOCK_COUNT_DEF);
          pool_linked = 1'b1;
        end
        if (size > BLOCK_BYTES || free_cnt == 0) begin
          r.status = 1'b1;
        end else begin
          r.granted = list_head;
          list_head = succ_link[list_head];
          free_cnt  = free_cnt - 1'b1;
        end
      end
      OP_RELEASE: begin
        if (pool_linked && !is_null && free_cnt < CNT_W'(BLOCK_COUNT_DEF)) begin
          succ_link[idx] = list_head;
          list_head      = idx;
          free_cnt       = free_cnt + 1'b1;
        end
      end
      OP_STATS: begin
        if (pool_linked) begin
          r.total = CNT_W'(BLOCK_COUNT_DEF);
          r.avail = free_cnt;
          r.used  = CNT_W'(BLOCK_COUNT_DEF) - free_cnt;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] rand_size();
    case ($urandom_range(9))
      0:       return SIZE_W'($urandom);
      1:       return SIZE_W'($urandom_range(32'hFFFF, 32'(BLOCK_BYTES) + 1));
      2:       return BLOCK_BYTES;
      3:       return '0;
      default: return SIZE_W'($urandom_range(32'(BLOCK_BYTES)));
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (error_count < 100) begin
      $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    end
    error_count++;
  endtask

  task automatic send_word(op_t op, logic [SIZE_W-1:0] size,
                           logic [IDX_W-1:0] idx, logic is_null);
    reply_t r;
    while (!quiet_run && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.opcode          <= op;
    in_ch.request_size    <= size;
    in_ch.release_index   <= idx;
    in_ch.release_is_null <= is_null;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = pool_step(op, size, idx, is_null);
    pool_replies.push_back(r);
    if (op == OP_ALLOC && !r.status) held_blocks.push_back(r.granted);
  endtask

  task automatic release_held();
    int               k;
    logic [IDX_W-1:0] blk;
    k   = $urandom_range(held_blocks.size() - 1);
    blk = held_blocks[k];
    held_blocks.delete(k);
    send_word(OP_RELEASE, SIZE_W'($urandom), blk, 1'b0);
  endtask

  task automatic test_before_link();
    send_word(OP_STATS, '0, '0, 1'b0);
    send_word(OP_RELEASE, '0, 5'd31, 1'b0);
    send_word(OP_RELEASE, '0, 5'd0, 1'b1);
    send_word(OP_NOP, 16'hFFFF, 5'd31, 1'b1);
    send_word(OP_STATS, 16'hFFFF, 5'd31, 1'b1);
  endtask

  task automatic test_first_alloc();
    // oversized request still links the pool
    send_word(OP_ALLOC, 16'hFFFF, '0, 1'b0);
    send_word(OP_STATS, '0, '0, 1'b0);
    send_word(OP_ALLOC, BLOCK_BYTES, '0, 1'b0);
    send_word(OP_ALLOC, BLOCK_BYTES + 1'b1, '0, 1'b0);
    send_word(OP_ALLOC, '0, 5'd31, 1'b1);
    send_word(OP_RELEASE, '0, 5'd1, 1'b1);
    send_word(OP_RELEASE, '0, 5'd0, 1'b0);
    send_word(OP_RELEASE, '0, 5'd1, 1'b0);
    // list full, ignored
    send_word(OP_RELEASE, '0, 5'd31, 1'b0);
    send_word(OP_STATS, '0, '0, 1'b0);
  endtask

  task automatic test_double_release();
    send_word(OP_ALLOC, 16'd1, '0, 1'b0);
    send_word(OP_ALLOC, 16'd63, '0, 1'b0);
    send_word(OP_RELEASE, '0, 5'd1, 1'b0);
    send_word(OP_RELEASE, '0, 5'd1, 1'b0);
    send_word(OP_ALLOC, 16'd2, '0, 1'b0);
    send_word(OP_ALLOC, 16'd3, '0, 1'b0);
    send_word(OP_STATS, '0, '0, 1'b0);
    held_blocks.delete();
  endtask

  task automatic test_drain_refill(int rounds);
    repeat (rounds) begin
      while (free_cnt != 0) send_word(OP_ALLOC, SIZE_W'($urandom_range(32'(BLOCK_BYTES))),
                                      IDX_W'($urandom), 1'($urandom));
      send_word(OP_ALLOC, 16'd1, '0, 1'b0);
      send_word(OP_STATS, '0, '0, 1'b0);
      while (held_blocks.size() != 0) release_held();
      send_word(OP_STATS, '0, '0, 1'b0);
    end
  endtask

  task automatic test_random_traffic(int n_items, int alloc_pct);
    int done;
    int pick;
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(99);
      if (pick < alloc_pct) begin
        send_word(OP_ALLOC, rand_size(), IDX_W'($urandom), 1'($urandom));
        done++;
      end else if (pick < 88 && held_blocks.size() != 0) begin
        release_held();
        done++;
      end else if (pick < 92) begin
        send_word(OP_RELEASE, SIZE_W'($urandom), IDX_W'($urandom), 1'($urandom));
      end else if (pick < 97) begin
        send_word(OP_STATS, SIZE_W'($urandom), IDX_W'($urandom), 1'($urandom));
        done++;
      end else begin
        send_word(OP_NOP, SIZE_W'($urandom), IDX_W'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic test_no_idle_stretch(int n_items);
    quiet_run = 1'b1;
    test_random_traffic(n_items, 50);
    quiet_run = 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= quiet_run || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pool_replies.size() == 0) begin
        report_mismatch("word with none pending", 1, 0);
      end else begin
        want = pool_replies.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", out_ch.status, want.status);
        if (out_ch.granted_index !== want.granted)
          report_mismatch("granted_index", out_ch.granted_index, want.granted);
        if (out_ch.total_blocks !== want.total)
          report_mismatch("total_blocks", out_ch.total_blocks, want.total);
        if (out_ch.used_blocks !== want.used)
          report_mismatch("used_blocks", out_ch.used_blocks, want.used);
        if (out_ch.free_blocks !== want.avail)
          report_mismatch("free_blocks", out_ch.free_blocks, want.avail);
      end
    end
  end

  initial begin
    quiet_run             = 1'b0;
    pool_linked           = 1'b0;
    list_head             = '0;
    free_cnt              = '0;
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.opcode          <= OP_NOP;
    in_ch.request_size    <= '0;
    in_ch.release_index   <= '0;
    in_ch.release_is_null <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_before_link();
    test_first_alloc();
    test_double_release();
    test_drain_refill(2);
    test_random_traffic(130, 70);
    test_random_traffic(130, 30);
    test_no_idle_stretch(150);

    in_ch.valid <= 1'b0;
    while (pool_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
hdl/fbpa_pkg.sv
hdl/fbpa_ifs.sv
hdl/fbpa_ram.sv
hdl/fbpa_ctrl.sv
hdl/fixed_block_pool_allocator_unit.sv
tb/sv/tb.sv
